@@ hdl/pbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Power button sequencer package
// Phase codes, register indexes, reset values and field positions shared by
// the sequencer and its checker.
// ----------------------------------------------------------------------------
package pbs_pkg;

    // Sequencer phase.
    typedef enum logic [1:0] {
        PH_OFF      = 2'd0,
        PH_POWERING = 2'd1,
        PH_ON       = 2'd2,
        PH_HELD     = 2'd3
    } t_phase;

    // Configuration register indexes.
    localparam logic REG_LONG_PRESS_POLLS = 1'b0;
    localparam logic REG_BLINK_DIVIDE     = 1'b1;

    // Register widths and reset values.
    localparam int unsigned CFG_WIDTH         = 8;
    localparam logic [7:0]  LONG_PRESS_RESET  = 8'd30;
    localparam logic [7:0]  BLINK_DIVIDE_RESET = 8'd2;

    // Bit positions in the input beat.
    localparam int unsigned IN_SWITCH  = 0;
    localparam int unsigned IN_CONFIRM = 1;
    localparam int unsigned IN_POLL    = 2;
    localparam int unsigned IN_BLINK   = 3;

    // Bit positions in the result beat.
    localparam int unsigned OUT_POWER_EN_N = 0;
    localparam int unsigned OUT_LED        = 1;
    localparam int unsigned OUT_REQUEST    = 2;
    localparam int unsigned OUT_POWERED    = 3;

    // One result beat.
    typedef struct packed {
        logic powered;
        logic shutdown_request;
        logic led_on;
        logic power_enable_n;
    } t_result;

endpackage

@@ hdl/power_button_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// Power button sequencer
// Turns sampled push switch levels, host confirmations and timer ticks into
// power enable, LED and shutdown request levels, one result per time step.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents (lowest bit first)
//  s_axis    in         button_down, poweroff_confirm, poll_tick, blink_tick
//  m_axis    out        power_enable_n, led_on, shutdown_request, powered
//  cfg       in         index 0 long_press_polls, index 1 blink_divide
//
// Each beat updates the phase machine and its two counters in the cycle it is
// accepted, and the result is registered for output.
// A beat can be accepted every cycle while the skid register is empty.
// A two-entry output buffer (result register plus skid register) keeps input
// flowing while a result waits; s_axis stalls only when both are full.
// Reset is synchronous and active low; it restores the register defaults and
// the off phase, and empties the output buffer.
//
module power_button_sequencer_top
    import pbs_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input beats.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [0] button_down, [1] poweroff_confirm, [2] poll_tick, [3] blink_tick,
    // [7:4] zero
    input  logic [7:0]           i_s_axis_tdata,
    // Result beats.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [0] power_enable_n, [1] led_on, [2] shutdown_request, [3] powered,
    // [7:4] zero
    output logic [7:0]           o_m_axis_tdata,
    // Configuration writes.
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    localparam int unsigned CW = COUNT_WIDTH;

    // Configuration registers.
    logic [CFG_WIDTH-1:0] r_long_press_polls;
    logic [CFG_WIDTH-1:0] r_blink_divide;

    // Sequencer state.
    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_press_remaining, n_press_remaining;
    logic [CW-1:0] r_blink_counter, n_blink_counter;
    logic          r_blink_phase, n_blink_phase;
    logic          r_blink_active, n_blink_active;
    logic          r_led_level, n_led_level;
    logic          r_request_level, n_request_level;
    logic          r_power_on_flag, n_power_on_flag;

    // Output buffer.
    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    // Registers cut to the counter width.
    logic [CW+CFG_WIDTH-1:0] long_press_ext, blink_divide_ext;
    logic [CW-1:0]           long_press_cut, blink_divide_cut;
    logic [CW-1:0]           blink_counter_inc;

    logic sw, confirm, poll, blink;
    logic in_fire, out_fire;

    assign sw      = i_s_axis_tdata[IN_SWITCH];
    assign confirm = i_s_axis_tdata[IN_CONFIRM];
    assign poll    = i_s_axis_tdata[IN_POLL];
    assign blink   = i_s_axis_tdata[IN_BLINK];

    assign long_press_ext   = {{CW{1'b0}}, r_long_press_polls};
    assign blink_divide_ext = {{CW{1'b0}}, r_blink_divide};
    assign long_press_cut   = long_press_ext[CW-1:0];
    assign blink_divide_cut = blink_divide_ext[CW-1:0];
    assign blink_counter_inc = r_blink_counter + {{(CW-1){1'b0}}, 1'b1};

    assign o_s_axis_tready = !r_skid_valid;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire        = r_out_valid && i_m_axis_tready;

    // Configuration writes; an index beyond the list cannot be encoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_polls <= LONG_PRESS_RESET;
            r_blink_divide     <= BLINK_DIVIDE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LONG_PRESS_POLLS: r_long_press_polls <= i_cfg_data;
                REG_BLINK_DIVIDE:     r_blink_divide     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state and result for the beat on the input.
    always_comb begin
        n_phase           = r_phase;
        n_press_remaining = r_press_remaining;
        n_blink_counter   = r_blink_counter;
        n_blink_phase     = r_blink_phase;
        n_blink_active    = r_blink_active;
        n_led_level       = r_led_level;
        n_request_level   = r_request_level;
        n_power_on_flag   = r_power_on_flag;

        case (r_phase)
            PH_OFF: begin
                if (sw) begin
                    n_led_level = 1'b1;
                    n_phase     = PH_POWERING;
                end
            end
            PH_POWERING: begin
                if (!sw) begin
                    n_power_on_flag = 1'b1;
                    n_phase         = PH_ON;
                end
            end
            PH_ON: begin
                if (sw) begin
                    // A press raises the request and starts the blink pattern.
                    n_request_level   = 1'b1;
                    n_led_level       = 1'b1;
                    n_blink_counter   = '0;
                    n_blink_phase     = 1'b1;
                    n_blink_active    = 1'b1;
                    n_press_remaining = long_press_cut;
                    n_phase           = PH_HELD;
                end else if (confirm) begin
                    n_power_on_flag   = 1'b0;
                    n_led_level       = 1'b0;
                    n_request_level   = 1'b0;
                    n_blink_active    = 1'b0;
                    n_blink_phase     = 1'b0;
                    n_blink_counter   = '0;
                    n_press_remaining = '0;
                    n_phase           = PH_OFF;
                end else if (blink && r_blink_active) begin
                    if (blink_counter_inc == blink_divide_cut) begin
                        n_blink_counter = '0;
                        n_request_level = !r_blink_phase;
                        n_led_level     = !r_blink_phase;
                        n_blink_phase   = !r_blink_phase;
                    end else begin
                        n_blink_counter = blink_counter_inc;
                    end
                end
            end
            default: begin
                // Held press: count polls down, force power off; release exits.
                if (sw) begin
                    if (poll) begin
                        if (r_press_remaining != '0) begin
                            n_press_remaining = r_press_remaining - {{(CW-1){1'b0}}, 1'b1};
                        end else if (r_power_on_flag) begin
                            n_power_on_flag   = 1'b0;
                            n_led_level       = 1'b0;
                            n_request_level   = 1'b0;
                            n_blink_active    = 1'b0;
                            n_blink_phase     = 1'b0;
                            n_blink_counter   = '0;
                        end
                    end
                end else if (confirm || !r_power_on_flag) begin
                    n_power_on_flag   = 1'b0;
                    n_led_level       = 1'b0;
                    n_request_level   = 1'b0;
                    n_blink_active    = 1'b0;
                    n_blink_phase     = 1'b0;
                    n_blink_counter   = '0;
                    n_press_remaining = '0;
                    n_phase           = PH_OFF;
                end else begin
                    n_phase = PH_ON;
                end
            end
        endcase

        n_result.power_enable_n   = !((n_phase == PH_POWERING) || n_power_on_flag);
        n_result.led_on           = n_led_level;
        n_result.shutdown_request = n_request_level;
        n_result.powered          = n_power_on_flag;
    end

    // State registers advance once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_OFF;
            r_press_remaining <= '0;
            r_blink_counter   <= '0;
            r_blink_phase     <= 1'b0;
            r_blink_active    <= 1'b0;
            r_led_level       <= 1'b0;
            r_request_level   <= 1'b0;
            r_power_on_flag   <= 1'b0;
        end else if (in_fire) begin
            r_phase           <= n_phase;
            r_press_remaining <= n_press_remaining;
            r_blink_counter   <= n_blink_counter;
            r_blink_phase     <= n_blink_phase;
            r_blink_active    <= n_blink_active;
            r_led_level       <= n_led_level;
            r_request_level   <= n_request_level;
            r_power_on_flag   <= n_power_on_flag;
        end
    end

    // Output buffer: the skid register catches a result while the output stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload of the output buffer.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out};

endmodule

@@ hdl/pbs_checker.sv @@
// ----------------------------------------------------------------------------
// Power button sequencer checker
// Port-level checks on the result stream and the output buffer, bound to the
// top level.
// ----------------------------------------------------------------------------
module pbs_checker
    import pbs_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat withdrawn while stalled");

    // A stalled result keeps its payload.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result payload changed while stalled");

    // Reset empties the output buffer.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("output buffer not empty after reset");

    // With both entries full and the output stalled, the input stays held off.
    a_full_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready && o_m_axis_tvalid && !i_m_axis_tready |=> !o_s_axis_tready)
        else $error("skid entry lost while output stalled");

    // The shutdown request is only ever shown with the LED lit.
    a_request_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[OUT_REQUEST] |-> o_m_axis_tdata[OUT_LED])
        else $error("shutdown request without LED");

endmodule

bind power_button_sequencer_top pbs_checker u_pbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
